FILE: sv/u8s_pkg.sv
package u8s_pkg;

    localparam int CP_W = 21;
    localparam int CH_W = 7;

    localparam logic [CH_W-1:0] CH_SPACE     = 7'h20;
    localparam logic [CH_W-1:0] CASE_OFFSET  = 7'h20;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] text_byte;
    } t_item;

    typedef struct packed {
        logic [CH_W-1:0] out_char;
        logic            space_before;
        logic            text_end;
        logic            text_empty;
    } t_result;

    typedef struct packed {
        logic            keep;
        logic            is_space;
        logic [CH_W-1:0] ch;
    } t_filt;

    // ASCII class: uppercase letters, keep digits and - / : . + % ~
    function automatic t_filt f_filter(input logic [CH_W-1:0] c);
        t_filt f;
        f.keep     = 1'b0;
        f.is_space = 1'b0;
        f.ch       = c;
        case (c) inside
            CH_SPACE: begin
                f.is_space = 1'b1;
            end
            [7'h61:7'h7A]: begin
                f.keep = 1'b1;
                f.ch   = c - CASE_OFFSET;
            end
            [7'h41:7'h5A], [7'h30:7'h39],
            7'h2D, 7'h2F, 7'h3A, 7'h2E, 7'h2B, 7'h25, 7'h7E: begin
                f.keep = 1'b1;
            end
            default: begin
                f.keep = 1'b0;
            end
        endcase
        return f;
    endfunction

endpackage

FILE: sv/u8s_if.sv
interface u8s_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] text_byte;

    modport source (output valid, output op, output text_byte, input ready);
    modport sink   (input valid, input op, input text_byte, output ready);
endinterface

interface u8s_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       space_before;
    logic       text_end;
    logic       text_empty;

    modport source (output valid, output out_char, output space_before,
                    output text_end, output text_empty, input ready);
    modport sink   (input valid, input out_char, input space_before,
                    input text_end, input text_empty, output ready);
endinterface

FILE: sv/utf8_ascii_text_sanitizer.sv
// Channel  | Dir | Fields
// i_in     | in  | op, text_byte
// o_out    | out | out_char, space_before, text_end, text_empty
//
// One byte per cycle while the output is not stalled; a byte passes the input register, then the output register.
// An input register feeds the decode/filter stage, which updates the
// sequence state and loads the output register in the same cycle.
// Synchronous active-low reset clears state and both valid flags.
// A stalled output holds the pipe; the input register still takes a
// byte while the output waits, then stalls.
module utf8_ascii_text_sanitizer
    import u8s_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    u8s_in_if.sink     i_in,
    u8s_out_if.source  o_out
);

    logic  s_valid;
    t_item s_item;
    logic  s_ready;

    u8s_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (s_valid),
        .o_item  (s_item),
        .i_ready (s_ready)
    );

    u8s_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .i_item  (s_item),
        .o_ready (s_ready),
        .o_out   (o_out)
    );

endmodule

FILE: sv/u8s_in_reg.sv
module u8s_in_reg
    import u8s_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    u8s_in_if.sink     i_in,
    output logic       o_valid,
    output t_item      o_item,
    input  logic       i_ready
);

    logic  r_valid;
    t_item r_item;
    logic  in_ready;

    assign in_ready   = !r_valid || i_ready;
    assign i_in.ready = in_ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_item.op        <= i_in.op;
            r_item.text_byte <= i_in.text_byte;
        end
    end

endmodule

FILE: sv/u8s_core.sv
module u8s_core
    import u8s_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_ready,
    u8s_out_if.source  o_out
);

    logic [1:0]      r_pend, n_pend;
    logic [CP_W-1:0] r_pc, n_pc;
    logic            r_any, n_any;
    logic            r_space, n_space;
    logic            r_out_valid;
    t_result         r_res, n_res;

    logic            advance;
    logic            fire;
    logic            emit;
    logic            cont;
    logic            do_filter;
    logic [CP_W-1:0] cp;
    t_filt           filt;
    logic [7:0]      b;

    assign advance = !r_out_valid || o_out.ready;
    assign fire    = i_valid && advance;
    assign o_ready = advance;
    assign b       = i_item.text_byte;
    assign cont    = (r_pend != 2'd0) && (b[7:6] == 2'b10);

    always_comb begin
        n_pend    = r_pend;
        n_pc      = r_pc;
        n_any     = r_any;
        n_space   = r_space;
        n_res     = '0;
        emit      = 1'b0;
        do_filter = 1'b0;
        cp        = '0;
        filt      = '0;
        if (i_item.op == OP_END) begin
            emit             = 1'b1;
            n_res.text_end   = 1'b1;
            n_res.text_empty = !r_any;
            n_pend           = '0;
            n_pc             = '0;
            n_any            = 1'b0;
            n_space          = 1'b0;
        end else begin
            if (cont) begin
                n_pc   = {r_pc[CP_W-7:0], b[5:0]};
                n_pend = r_pend - 2'd1;
                if (r_pend == 2'd1) begin
                    cp        = n_pc;
                    do_filter = 1'b1;
                    n_pc      = '0;
                end
            end else begin
                // new lead; a bad continuation drops the open sequence
                n_pend = '0;
                n_pc   = '0;
                case (b) inside
                    8'b0???????: begin
                        cp        = CP_W'(b[6:0]);
                        do_filter = 1'b1;
                    end
                    8'b110?????: begin
                        n_pend = 2'd1;
                        n_pc   = CP_W'(b[4:0]);
                    end
                    8'b1110????: begin
                        n_pend = 2'd2;
                        n_pc   = CP_W'(b[3:0]);
                    end
                    8'b11110???: begin
                        n_pend = 2'd3;
                        n_pc   = CP_W'(b[2:0]);
                    end
                    default: begin
                        n_pend = '0;
                    end
                endcase
            end
            filt = f_filter(cp[CH_W-1:0]);
            if (do_filter && (cp[CP_W-1:CH_W] == '0)) begin
                if (filt.is_space) begin
                    if (r_any) begin
                        n_space = 1'b1;
                    end
                end else if (filt.keep) begin
                    emit               = 1'b1;
                    n_res.out_char     = filt.ch;
                    n_res.space_before = r_space;
                    n_space            = 1'b0;
                    n_any              = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_pc        <= '0;
            r_any       <= 1'b0;
            r_space     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_pend  <= n_pend;
                r_pc    <= n_pc;
                r_any   <= n_any;
                r_space <= n_space;
            end
            if (advance) begin
                r_out_valid <= fire && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_char     = r_res.out_char;
    assign o_out.space_before = r_res.space_before;
    assign o_out.text_end     = r_res.text_end;
    assign o_out.text_empty   = r_res.text_empty;

`ifndef SYNTHESIS
    a_pc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 2'd0) |-> (r_pc == '0))
        else $error("partial codepoint set with no sequence open");

    a_space_needs_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_space |-> r_any)
        else $error("space pending before any kept character");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (i_item.op == OP_END)) |=>
            ((r_pend == 2'd0) && !r_any && !r_space && r_out_valid && r_res.text_end))
        else $error("end transaction did not close the text");

    a_end_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.text_end) |-> ((r_res.out_char == '0) && !r_res.space_before))
        else $error("end result carries a character");

    a_char_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.text_end) |-> (!r_res.text_empty && (r_res.out_char != '0)))
        else $error("character result malformed");
`endif

endmodule
